[sv/sbd_pkg.sv]
// Package for the SBUS frame decoder: transfer types and frame constants.
package sbd_pkg;

    localparam int FRAME_LEN      = 25;
    localparam int RX_BUF_LEN_DEF = 32;
    localparam int NUM_CHANNELS   = 16;
    localparam int CH_IDX_W       = 4;
    localparam int CHAN_W         = 11;
    localparam int FIRST_DATA     = 1;
    localparam int NUM_DATA       = 22;
    localparam int STREAM_W       = NUM_DATA * 8;
    localparam int FLAG_POS       = 23;

    localparam logic [7:0] SBUS_HEADER = 8'h0F;
    localparam logic [7:0] SBUS_FOOTER = 8'h00;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_IDLE = 1'b1;

    localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(NUM_CHANNELS - 1);

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [CH_IDX_W-1:0] channel_index;
        logic [CHAN_W-1:0]   channel_value;
        logic [7:0]          frame_flags;
        logic                last_channel;
    } t_out_item;

endpackage

[sv/sbus_frame_decoder_core.sv]
// SBUS frame decoder top level: byte capture, frame check and channel emission.
//
//  channel | dir | payload                 | handshake
//  --------+-----+-------------------------+---------------------------
//  in      | in  | sbd_pkg::t_in_item      | i_in_valid / o_in_ready
//  out     | out | sbd_pkg::t_out_item     | o_out_valid / i_out_ready
//
// A byte transfer is taken every cycle and produces nothing; up to 25 bytes
// shift into a 25-byte shift line. A good idle loads the result register in
// the next cycle and 16 results follow, one per cycle while i_out_ready is high.
// An idle is held off only while a previous frame is still draining, except in
// the cycle its last result is taken. Reset clears the count and the output.
module sbus_frame_decoder_core #(
    parameter int RX_BUF_LEN = sbd_pkg::RX_BUF_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sbd_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sbd_pkg::t_out_item  o_out
);

    localparam int CNT_W = $clog2(RX_BUF_LEN + 1);

    logic [7:0]                     r_frame [sbd_pkg::FRAME_LEN];
    logic [CNT_W-1:0]               r_count;
    logic                           r_out_valid;
    sbd_pkg::t_out_item             r_out;
    logic [sbd_pkg::STREAM_W-1:0]   r_stream;

    logic                           n_out_valid;
    sbd_pkg::t_out_item             n_out;
    logic [sbd_pkg::STREAM_W-1:0]   n_stream;

    logic                           in_xfer;
    logic                           out_xfer;
    logic                           byte_xfer;
    logic                           idle_xfer;
    logic                           frame_ok;
    logic [sbd_pkg::STREAM_W-1:0]   stream;

    assign out_xfer  = r_out_valid && i_out_ready;
    assign o_in_ready = (i_in.req_type == sbd_pkg::REQ_BYTE) || !r_out_valid
                        || (i_out_ready && r_out.last_channel);
    assign in_xfer   = i_in_valid && o_in_ready;
    assign byte_xfer = in_xfer && (i_in.req_type == sbd_pkg::REQ_BYTE);
    assign idle_xfer = in_xfer && (i_in.req_type == sbd_pkg::REQ_IDLE);

    assign frame_ok = (r_count == CNT_W'(sbd_pkg::FRAME_LEN))
                      && (r_frame[0] == sbd_pkg::SBUS_HEADER)
                      && (r_frame[sbd_pkg::FRAME_LEN-1] == sbd_pkg::SBUS_FOOTER);

    always_comb begin
        for (int i = 0; i < sbd_pkg::NUM_DATA; i++) begin
            stream[i*8 +: 8] = r_frame[sbd_pkg::FIRST_DATA + i];
        end
    end

    // bytes shift in at the top; after a full frame byte 0 sits at entry 0
    always_ff @(posedge i_clk) begin
        if (byte_xfer && (r_count < CNT_W'(sbd_pkg::FRAME_LEN))) begin
            for (int i = 0; i < sbd_pkg::FRAME_LEN - 1; i++) begin
                r_frame[i] <= r_frame[i+1];
            end
            r_frame[sbd_pkg::FRAME_LEN-1] <= i_in.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (idle_xfer) begin
            r_count <= '0;
        end else if (byte_xfer && (r_count < CNT_W'(RX_BUF_LEN))) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_stream    = r_stream;
        if (out_xfer) begin
            if (r_out.last_channel) begin
                n_out_valid = 1'b0;
            end else begin
                n_out.channel_index = r_out.channel_index + sbd_pkg::CH_IDX_W'(1);
                n_out.channel_value = r_stream[sbd_pkg::CHAN_W-1:0];
                n_out.last_channel  = (n_out.channel_index == sbd_pkg::LAST_CH);
                n_stream            = r_stream >> sbd_pkg::CHAN_W;
            end
        end
        if (idle_xfer && frame_ok) begin
            n_out_valid         = 1'b1;
            n_out.channel_index = '0;
            n_out.channel_value = stream[sbd_pkg::CHAN_W-1:0];
            n_out.frame_flags   = r_frame[sbd_pkg::FLAG_POS];
            n_out.last_channel  = 1'b0;
            n_stream            = stream >> sbd_pkg::CHAN_W;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_stream <= n_stream;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_last_matches_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.last_channel == (o_out.channel_index == sbd_pkg::LAST_CH)))
        else $error("last marker does not match channel index");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out.last_channel) |=>
        (o_out_valid && (o_out.channel_index ==
            $past(o_out.channel_index) + sbd_pkg::CH_IDX_W'(1))))
        else $error("channel sequence broken");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RX_BUF_LEN))
        else $error("byte count beyond buffer size");

    a_idle_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        idle_xfer |=> (r_count == '0))
        else $error("idle did not clear byte count");

    a_no_idle_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (idle_xfer && r_out_valid) |-> (i_out_ready && r_out.last_channel))
        else $error("idle taken while a frame is draining");

endmodule

[sim/tb_sbus_frame_decoder_core.sv]
// Testbench for the SBUS frame decoder core: byte/idle streams checked against a frame predictor.
module tb_sbus_frame_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_LEN      = 32;
    localparam int RANDOM_ITEMS = 170;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 20;
    localparam int MAX_REPORTS  = 10;
    localparam int WRAP_LEN     = 64 + sbd_pkg::FRAME_LEN;

    typedef enum int {FILL_MIX, FILL_ONES, FILL_ZEROS} t_fill;

    typedef struct {
        sbd_pkg::t_in_item item;
        bit                wait_drain;
    } t_pending;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    sbd_pkg::t_in_item  i_in        = '0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    sbd_pkg::t_out_item o_out;

    t_pending           pending_q[$];
    sbd_pkg::t_out_item expected_channels[$];
    logic [7:0]         frame_copy [sbd_pkg::FRAME_LEN];
    logic [5:0]         rx_count       = '0;
    int                 mismatches     = 0;
    int                 idle_cycles    = 0;
    int                 cycle_cnt      = 0;
    int                 total_items    = 0;
    int                 accepted_items = 0;
    int                 send_gap       = 0;
    int                 recv_stall     = 0;
    bit                 in_taken       = 1'b0;
    bit                 end_phase      = 1'b0;

    sbus_frame_decoder_core #(
        .RX_BUF_LEN(BUF_LEN)
    ) i_dut (
        .*
    );

    always #1 i_clk = ~i_clk;

    // mostly short gaps, a few long ones, and a gap-free window that recurs periodically
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (((cycle_cnt / 256) % 4) == 3) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic string fmt_result(sbd_pkg::t_out_item r);
        return $sformatf("idx %0d value %0d flags %02h last %0b",
                         r.channel_index, r.channel_value, r.frame_flags, r.last_channel);
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
    endfunction

    function automatic void decode_event(sbd_pkg::t_in_item it);
        logic [sbd_pkg::STREAM_W-1:0] stream;
        sbd_pkg::t_out_item           r;
        if (it.req_type == sbd_pkg::REQ_BYTE) begin
            if (rx_count < sbd_pkg::FRAME_LEN) frame_copy[rx_count] = it.rx_byte;
            if (rx_count < BUF_LEN) rx_count = rx_count + 6'd1;
        end else begin
            if (rx_count == sbd_pkg::FRAME_LEN && frame_copy[0] == sbd_pkg::SBUS_HEADER
                    && frame_copy[sbd_pkg::FRAME_LEN-1] == sbd_pkg::SBUS_FOOTER) begin
                for (int k = 0; k < sbd_pkg::NUM_DATA; k++) begin
                    stream[k*8 +: 8] = frame_copy[sbd_pkg::FIRST_DATA + k];
                end
                for (int ch = 0; ch < sbd_pkg::NUM_CHANNELS; ch++) begin
                    r.channel_index = sbd_pkg::CH_IDX_W'(ch);
                    r.channel_value = stream[ch*sbd_pkg::CHAN_W +: sbd_pkg::CHAN_W];
                    r.frame_flags   = frame_copy[sbd_pkg::FLAG_POS];
                    r.last_channel  = (r.channel_index == sbd_pkg::LAST_CH);
                    expected_channels.push_back(r);
                end
            end
            rx_count = '0;
        end
    endfunction

    task automatic queue_item(logic req, logic [7:0] b, bit hold);
        t_pending p;
        p.item.req_type = req;
        p.item.rx_byte  = b;
        p.wait_drain    = hold;
        pending_q.push_back(p);
        total_items++;
    endtask

    function automatic logic [7:0] data_byte(t_fill fill);
        int r;
        r = $urandom_range(0, 7);
        case (fill)
            FILL_ONES:  return 8'hFF;
            FILL_ZEROS: return 8'h00;
            default: begin
                if (r == 0) return 8'h00;
                if (r == 1) return 8'hFF;
                return 8'($urandom);
            end
        endcase
    endfunction

    // header at byte 0, footer at byte 24 where the frame reaches it, then an idle
    task automatic queue_frame(int nbytes, logic [7:0] hdr, logic [7:0] ftr, t_fill fill,
                               bit hold);
        logic [7:0] b;
        for (int k = 0; k < nbytes; k++) begin
            if (k == 0) b = hdr;
            else if (k == sbd_pkg::FRAME_LEN - 1) b = ftr;
            else b = data_byte(fill);
            queue_item(sbd_pkg::REQ_BYTE, b, hold && k == 0);
        end
        queue_item(sbd_pkg::REQ_IDLE, 8'($urandom), hold && nbytes == 0);
    endtask

    task automatic build_stimulus();
        int         first_random;
        int         kind;
        int         n;
        logic [7:0] bad;
        bit         hold;
        queue_frame(0, sbd_pkg::SBUS_HEADER, sbd_pkg::SBUS_FOOTER, FILL_MIX, 1'b0);
        queue_frame(sbd_pkg::FRAME_LEN, sbd_pkg::SBUS_HEADER, sbd_pkg::SBUS_FOOTER,
                    FILL_ONES, 1'b0);
        queue_frame(sbd_pkg::FRAME_LEN, sbd_pkg::SBUS_HEADER, sbd_pkg::SBUS_FOOTER,
                    FILL_ZEROS, 1'b1);
        queue_frame(sbd_pkg::FRAME_LEN, 8'h8F, sbd_pkg::SBUS_FOOTER, FILL_MIX, 1'b0);
        queue_frame(sbd_pkg::FRAME_LEN, sbd_pkg::SBUS_HEADER, 8'h80, FILL_MIX, 1'b0);
        queue_frame(sbd_pkg::FRAME_LEN - 1, sbd_pkg::SBUS_HEADER, sbd_pkg::SBUS_FOOTER,
                    FILL_MIX, 1'b0);
        queue_frame(sbd_pkg::FRAME_LEN + 1, sbd_pkg::SBUS_HEADER, sbd_pkg::SBUS_FOOTER,
                    FILL_MIX, 1'b0);
        queue_frame(WRAP_LEN, sbd_pkg::SBUS_HEADER, sbd_pkg::SBUS_FOOTER, FILL_MIX, 1'b0);
        queue_item(sbd_pkg::REQ_IDLE, 8'hFF, 1'b0);
        queue_frame(sbd_pkg::FRAME_LEN, sbd_pkg::SBUS_HEADER, sbd_pkg::SBUS_FOOTER,
                    FILL_MIX, 1'b0);

        first_random = total_items;
        while (total_items - first_random < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            hold = ($urandom_range(0, 15) == 0);
            if (kind < 65) begin
                n = $urandom_range(0, 9);
                queue_frame(sbd_pkg::FRAME_LEN, sbd_pkg::SBUS_HEADER, sbd_pkg::SBUS_FOOTER,
                            (n == 0) ? FILL_ONES : (n == 1) ? FILL_ZEROS : FILL_MIX, hold);
            end else if (kind < 73) begin
                if ($urandom_range(0, 1)) begin
                    do bad = 8'($urandom); while (bad == sbd_pkg::SBUS_HEADER);
                    queue_frame(sbd_pkg::FRAME_LEN, bad, sbd_pkg::SBUS_FOOTER, FILL_MIX, hold);
                end else begin
                    bad = 8'($urandom_range(1, 255));
                    queue_frame(sbd_pkg::FRAME_LEN, sbd_pkg::SBUS_HEADER, bad, FILL_MIX, hold);
                end
            end else if (kind < 85) begin
                n = $urandom_range(0, BUF_LEN);
                if (n == sbd_pkg::FRAME_LEN) begin
                    n = $urandom_range(0, 1) ? sbd_pkg::FRAME_LEN + 1 : sbd_pkg::FRAME_LEN - 1;
                end
                queue_frame(n, sbd_pkg::SBUS_HEADER, sbd_pkg::SBUS_FOOTER, FILL_MIX, hold);
            end else if (kind < 88) begin
                n = ($urandom_range(0, 3) == 0) ? WRAP_LEN : $urandom_range(BUF_LEN + 1, 100);
                queue_frame(n, sbd_pkg::SBUS_HEADER, sbd_pkg::SBUS_FOOTER, FILL_MIX, hold);
            end else if (kind < 95) begin
                queue_item(sbd_pkg::REQ_IDLE, 8'($urandom), hold);
            end else begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) queue_item(sbd_pkg::REQ_BYTE, 8'($urandom), 1'b0);
            end
        end
    endtask

    // sample transfers, check results, update the prediction, watchdog
    always @(posedge i_clk) begin
        sbd_pkg::t_out_item want;
        cycle_cnt++;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_channels.size() == 0) begin
                    note_mismatch({"unexpected result: ", fmt_result(o_out)});
                end else begin
                    want = expected_channels.pop_front();
                    if (o_out.channel_index !== want.channel_index
                            || o_out.channel_value !== want.channel_value
                            || o_out.frame_flags !== want.frame_flags
                            || o_out.last_channel !== want.last_channel) begin
                        note_mismatch({"expected ", fmt_result(want), ", got ", fmt_result(o_out)});
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                in_taken = 1'b1;
                accepted_items++;
                decode_event(i_in);
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // inputs change on the falling edge
    always @(negedge i_clk) begin
        t_pending          nxt;
        logic              drive_valid;
        sbd_pkg::t_in_item drive_item;
        drive_valid = i_in_valid && !in_taken;
        drive_item  = i_in;
        in_taken    = 1'b0;
        if (i_rst_n && !drive_valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_q.size() > 0
                    && !(pending_q[0].wait_drain && expected_channels.size() > 0)) begin
                nxt         = pending_q.pop_front();
                drive_item  = nxt.item;
                drive_valid = 1'b1;
                send_gap    = pick_gap();
            end
        end
        i_in_valid <= drive_valid;
        i_in       <= drive_item;

        if (end_phase) begin
            i_out_ready <= 1'b1;
        end else if (recv_stall > 0) begin
            recv_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 4) == 0) recv_stall = pick_gap();
        end
    end

    initial begin
        build_stimulus();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (accepted_items < total_items || expected_channels.size() > 0) begin
            @(negedge i_clk);
        end
        end_phase = 1'b1;
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
